### sv/cpts_pkg.sv
package cpts_pkg;

  localparam int TASK_SLOTS_DEF = 64;

  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 6;
  localparam int STATE_W = 3;
  localparam int PRIO_W  = 7;
  localparam int CNT_W   = 8;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SCHED = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_EXIT  = 2'd3;

  localparam logic [STATE_W-1:0] ST_RUNNING = 3'd0;
  localparam logic [STATE_W-1:0] ST_ZOMBIE  = 3'd3;

  localparam logic [PRIO_W-1:0] INIT_PRIO  = 7'd15;
  localparam logic [CNT_W-1:0]  INIT_SLICE = 8'd15;

  typedef struct packed {
    logic               used;
    logic [STATE_W-1:0] state;
    logic [PRIO_W-1:0]  prio;
    logic [CNT_W-1:0]   cnt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic entry_t reset_entry(input logic is_slot0);
    entry_t e;
    e.used  = is_slot0;
    e.state = ST_RUNNING;
    e.prio  = is_slot0 ? INIT_PRIO : '0;
    e.cnt   = is_slot0 ? INIT_SLICE : '0;
    return e;
  endfunction

  function automatic logic [CNT_W-1:0] refill_cnt(input entry_t e);
    logic [CNT_W:0] sum;
    sum = {2'b00, e.cnt[CNT_W-1:1]} + {2'b00, e.prio};
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

endpackage

### sv/cpts_if.sv
interface cpts_in_if;
  logic                         valid;
  logic                         ready;
  logic [cpts_pkg::CMD_W-1:0]   cmd;
  logic [cpts_pkg::SLOT_W-1:0]  slot;
  logic [cpts_pkg::STATE_W-1:0] run_state;
  logic [cpts_pkg::PRIO_W-1:0]  priority_req;
  logic [cpts_pkg::CNT_W-1:0]   start_counter;
  logic                         slot_valid;

  modport source (output valid, cmd, slot, run_state, priority_req, start_counter,
                  slot_valid, input ready);
  modport sink   (input valid, cmd, slot, run_state, priority_req, start_counter,
                  slot_valid, output ready);
endinterface

interface cpts_out_if;
  logic                        valid;
  logic                        ready;
  logic [cpts_pkg::SLOT_W-1:0] current_task;
  logic                        switched;
  logic                        recomputed;
  logic                        none_ready;
  logic [cpts_pkg::CNT_W-1:0]  current_counter;

  modport source (output valid, current_task, switched, recomputed, none_ready,
                  current_counter, input ready);
  modport sink   (input valid, current_task, switched, recomputed, none_ready,
                  current_counter, output ready);
endinterface

### sv/cpts_ram.sv
module cpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/counter_priority_task_scheduler.sv
// Counter/priority task scheduler.
// in_i carries one command beat: timer tick, schedule request, slot write or
// exit of the current task, with the slot fields used by slot writes.
// out_o returns exactly one beat per command: current task, its counter and
// the switched / recomputed / none_ready flags of the scheduling pass.
// Slot entries live in one synchronous RAM, one entry per slot; a flop per
// slot marks entries written since reset, unwritten ones read as their reset
// value, so no clearing pass is needed after reset.
// One command is worked at a time; in_i.ready is high only when idle.
// A slot write or a plain tick runs no scheduling pass. A pass reads every
// slot through the RAM read port, one per cycle; a schedule request, an exit
// or a tick that ends the slice runs one pass, and a refill adds a second
// pass that writes each used entry back while the next one is read.
// A result waits in the output register while out_o.ready is low; the block
// holds there until the register frees, then becomes ready again.
// Reset (rst_ni low, async) restores slot 0 as the only task with priority
// and counter 15, and makes slot 0 current.
module counter_priority_task_scheduler #(
  parameter int TASK_SLOTS = cpts_pkg::TASK_SLOTS_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  cpts_in_if.sink    in_i,
  cpts_out_if.source out_o
);
  import cpts_pkg::*;

  localparam int IW = $clog2(TASK_SLOTS);
  localparam int CW = IW + 1;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_CUR_MOD = 6'b000010,
    S_SCAN    = 6'b000100,
    S_DECIDE  = 6'b001000,
    S_FIN_RD  = 6'b010000,
    S_OUT     = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CMD_W-1:0]      cmd_q, cmd_d;
  logic [IW-1:0]         cur_q, cur_d;
  logic [TASK_SLOTS-1:0] written_q, written_d;
  logic [IW-1:0]         rd_addr_q, rd_addr_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic                  pv_q, pv_d;
  logic [IW-1:0]         pidx_q, pidx_d;
  logic                  refill_q, refill_d;
  logic                  found_q, found_d;
  logic [CNT_W-1:0]      best_cnt_q, best_cnt_d;
  logic [IW-1:0]         best_idx_q, best_idx_d;
  logic                  sw_q, sw_d, rec_q, rec_d, none_q, none_d;

  logic                  out_valid_q, out_valid_d;
  logic [SLOT_W-1:0]     out_task_q, out_task_d;
  logic                  out_sw_q, out_sw_d, out_rec_q, out_rec_d, out_none_q, out_none_d;
  logic [CNT_W-1:0]      out_cnt_q, out_cnt_d;

  logic                  ram_we, ram_re;
  logic [IW-1:0]         ram_waddr, ram_raddr;
  entry_t                ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;

  entry_t                rd_e;
  entry_t                mod_e;
  logic                  in_acc;
  logic                  slot_in_range;
  logic                  out_free;

  cpts_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TASK_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_e = written_q[rd_addr_q] ? entry_t'(ram_rdata) : reset_entry(rd_addr_q == '0);

  assign in_i.ready    = (state_q == S_IDLE);
  assign in_acc        = in_i.valid && in_i.ready;
  assign slot_in_range = {{(32-SLOT_W){1'b0}}, in_i.slot} < 32'(TASK_SLOTS);
  assign out_free      = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cur_d       = cur_q;
    written_d   = written_q;
    rd_addr_d   = rd_addr_q;
    idx_d       = idx_q;
    pv_d        = 1'b0;
    pidx_d      = pidx_q;
    refill_d    = refill_q;
    found_d     = found_q;
    best_cnt_d  = best_cnt_q;
    best_idx_d  = best_idx_q;
    sw_d        = sw_q;
    rec_d       = rec_q;
    none_d      = none_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_task_d  = out_task_q;
    out_sw_d    = out_sw_q;
    out_rec_d   = out_rec_q;
    out_none_d  = out_none_q;
    out_cnt_d   = out_cnt_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = cur_q;
    ram_raddr   = cur_q;
    ram_wdata   = rd_e;
    mod_e       = rd_e;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d      = in_i.cmd;
          sw_d       = 1'b0;
          rec_d      = 1'b0;
          none_d     = 1'b0;
          refill_d   = 1'b0;
          found_d    = 1'b0;
          idx_d      = '0;
          case (in_i.cmd)
            CMD_WRITE: begin
              ram_we          = slot_in_range;
              ram_waddr       = IW'(in_i.slot);
              ram_wdata.used  = in_i.slot_valid;
              ram_wdata.state = in_i.run_state;
              ram_wdata.prio  = in_i.priority_req;
              ram_wdata.cnt   = in_i.start_counter;
              if (slot_in_range) begin
                written_d[IW'(in_i.slot)] = 1'b1;
              end
              state_d = S_FIN_RD;
            end
            CMD_SCHED: begin
              state_d = S_SCAN;
            end
            default: begin
              ram_re    = 1'b1;
              rd_addr_d = cur_q;
              state_d   = S_CUR_MOD;
            end
          endcase
        end
      end

      S_CUR_MOD: begin
        ram_we    = 1'b1;
        ram_waddr = cur_q;
        written_d[cur_q] = 1'b1;
        if (cmd_q == CMD_EXIT) begin
          mod_e.state = ST_ZOMBIE;
          state_d     = S_SCAN;
        end else if (rd_e.cnt > 8'd1) begin
          mod_e.cnt = rd_e.cnt - 8'd1;
          state_d   = S_FIN_RD;
        end else begin
          mod_e.cnt = '0;
          state_d   = S_SCAN;
        end
        ram_wdata = mod_e;
      end

      S_SCAN: begin
        if (idx_q < CW'(TASK_SLOTS)) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q[IW-1:0];
          rd_addr_d = idx_q[IW-1:0];
          pidx_d    = idx_q[IW-1:0];
          pv_d      = 1'b1;
          idx_d     = idx_q + CW'(1);
        end else if (!pv_q) begin
          state_d = S_DECIDE;
        end
        if (pv_q) begin
          if (refill_q && rd_e.used) begin
            mod_e.cnt = refill_cnt(rd_e);
            ram_we    = 1'b1;
            ram_waddr = pidx_q;
            ram_wdata = mod_e;
            written_d[pidx_q] = 1'b1;
          end
          if (mod_e.used && mod_e.state == ST_RUNNING &&
              (!found_q || mod_e.cnt > best_cnt_q)) begin
            found_d    = 1'b1;
            best_cnt_d = mod_e.cnt;
            best_idx_d = pidx_q;
          end
        end
      end

      S_DECIDE: begin
        if (found_q && best_cnt_q == '0 && !refill_q) begin
          refill_d = 1'b1;
          rec_d    = 1'b1;
          found_d  = 1'b0;
          idx_d    = '0;
          state_d  = S_SCAN;
        end else if (!found_q || best_cnt_q == '0) begin
          none_d  = 1'b1;
          state_d = S_FIN_RD;
        end else begin
          cur_d   = best_idx_q;
          sw_d    = 1'b1;
          state_d = S_FIN_RD;
        end
      end

      S_FIN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = cur_q;
        rd_addr_d = cur_q;
        state_d   = S_OUT;
      end

      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_task_d  = SLOT_W'(cur_q);
          out_sw_d    = sw_q;
          out_rec_d   = rec_q;
          out_none_d  = none_q;
          out_cnt_d   = rd_e.cnt;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      written_q   <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      written_q   <= written_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    rd_addr_q  <= rd_addr_d;
    idx_q      <= idx_d;
    pidx_q     <= pidx_d;
    refill_q   <= refill_d;
    found_q    <= found_d;
    best_cnt_q <= best_cnt_d;
    best_idx_q <= best_idx_d;
    sw_q       <= sw_d;
    rec_q      <= rec_d;
    none_q     <= none_d;
    out_task_q <= out_task_d;
    out_sw_q   <= out_sw_d;
    out_rec_q  <= out_rec_d;
    out_none_q <= out_none_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.current_task    = out_task_q;
  assign out_o.switched        = out_sw_q;
  assign out_o.recomputed      = out_rec_q;
  assign out_o.none_ready      = out_none_q;
  assign out_o.current_counter = out_cnt_q;

  a_no_rw_same_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("RAM read and write hit the same entry");

  a_sw_none_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.switched && out_o.none_ready))
    else $error("switched and none_ready both set");

  a_sw_cnt_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.switched |-> out_o.current_counter != '0)
    else $error("switched to a task with an empty slice");

  a_rec_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.recomputed |-> out_o.switched || out_o.none_ready)
    else $error("refill reported outside a scheduling pass");

  a_scan_idle_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pv_q)
    else $error("scan read pending while idle");

endmodule

### tb/counter_priority_task_scheduler_tb.sv
module counter_priority_task_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cpts_pkg::*;

  localparam int NSLOTS        = TASK_SLOTS_DEF;
  localparam int RANDOM_ITEMS  = 1900;
  localparam int DRAIN_CYCLES  = 2 * NSLOTS + 60;
  localparam int CYCLE_LIMIT   = 2_000_000;

  localparam logic [STATE_W-1:0] ST_INTR      = 3'd1;
  localparam logic [STATE_W-1:0] ST_UNINTR    = 3'd2;
  localparam logic [STATE_W-1:0] ST_STOPPED   = 3'd4;
  localparam logic [STATE_W-1:0] ST_UNDEF_MIN = 3'd5;
  localparam logic [STATE_W-1:0] ST_UNDEF_MAX = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [SLOT_W-1:0]  slot;
    logic [STATE_W-1:0] st;
    logic [PRIO_W-1:0]  prio;
    logic [CNT_W-1:0]   cnt;
    logic               in_set;
  } sched_cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] task_id;
    logic              switched;
    logic              recomputed;
    logic              none_ready;
    logic [CNT_W-1:0]  counter;
  } sched_result_t;

  logic clk_i;
  logic rst_ni;
  bit   idle_on;
  int   errors;
  int   stall_left;
  longint cycle_cnt;

  sched_result_t expected_q[$];

  logic               slot_in_set [NSLOTS];
  logic [STATE_W-1:0] slot_st     [NSLOTS];
  logic [PRIO_W-1:0]  slot_prio   [NSLOTS];
  logic [CNT_W-1:0]   slot_cnt    [NSLOTS];
  logic [SLOT_W-1:0]  cur_slot;

  cpts_in_if  cmd_if ();
  cpts_out_if res_if ();

  counter_priority_task_scheduler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------- scheduler predictor ----------------

  function automatic void reset_tasks();
    for (int i = 0; i < NSLOTS; i++) begin
      slot_in_set[i] = (i == 0);
      slot_st[i]     = ST_RUNNING;
      slot_prio[i]   = (i == 0) ? INIT_PRIO : '0;
      slot_cnt[i]    = (i == 0) ? INIT_SLICE : '0;
    end
    cur_slot = '0;
  endfunction

  function automatic int best_running_slot();
    int best;
    int best_cnt;
    best     = -1;
    best_cnt = -1;
    for (int i = 0; i < NSLOTS; i++) begin
      if (slot_in_set[i] && slot_st[i] == ST_RUNNING && int'(slot_cnt[i]) > best_cnt) begin
        best_cnt = int'(slot_cnt[i]);
        best     = i;
      end
    end
    return best;
  endfunction

  function automatic void schedule_pass(inout sched_result_t r);
    int best;
    int sum;
    best = best_running_slot();
    if (best >= 0 && slot_cnt[best] == 0) begin
      for (int i = 0; i < NSLOTS; i++) begin
        if (slot_in_set[i]) begin
          sum = int'(slot_cnt[i] >> 1) + int'(slot_prio[i]);
          slot_cnt[i] = (sum > 255) ? 8'hFF : sum[CNT_W-1:0];
        end
      end
      r.recomputed = 1'b1;
      best = best_running_slot();
    end
    if (best < 0 || slot_cnt[best] == 0) begin
      r.none_ready = 1'b1;
    end else begin
      cur_slot   = best[SLOT_W-1:0];
      r.switched = 1'b1;
    end
  endfunction

  function automatic sched_result_t next_schedule(input sched_cmd_t c);
    sched_result_t r;
    r = '0;
    case (c.cmd)
      CMD_TICK: begin
        if (slot_cnt[cur_slot] > 1) begin
          slot_cnt[cur_slot] = slot_cnt[cur_slot] - 1'b1;
        end else begin
          slot_cnt[cur_slot] = '0;
          schedule_pass(r);
        end
      end
      CMD_SCHED: schedule_pass(r);
      CMD_WRITE: begin
        if (int'(c.slot) < NSLOTS) begin
          slot_in_set[c.slot] = c.in_set;
          slot_st[c.slot]     = c.st;
          slot_prio[c.slot]   = c.prio;
          slot_cnt[c.slot]    = c.cnt;
        end
      end
      default: begin
        slot_st[cur_slot] = ST_ZOMBIE;
        schedule_pass(r);
      end
    endcase
    r.task_id = cur_slot;
    r.counter = slot_cnt[cur_slot];
    return r;
  endfunction

  // ---------------- driving ----------------

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_stall();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic issue(input sched_cmd_t c);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.cmd           <= c.cmd;
    cmd_if.slot          <= c.slot;
    cmd_if.run_state     <= c.st;
    cmd_if.priority_req  <= c.prio;
    cmd_if.start_counter <= c.cnt;
    cmd_if.slot_valid    <= c.in_set;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    expected_q.push_back(next_schedule(c));
  endtask

  function automatic sched_cmd_t noise_cmd();
    sched_cmd_t c;
    c = sched_cmd_t'($bits(sched_cmd_t)'($urandom));
    return c;
  endfunction

  function automatic sched_cmd_t op_cmd(input logic [CMD_W-1:0] op);
    sched_cmd_t c;
    c     = noise_cmd();
    c.cmd = op;
    return c;
  endfunction

  function automatic sched_cmd_t slot_write(input int s, input logic [STATE_W-1:0] st,
                                            input int p, input int n, input bit in_set);
    sched_cmd_t c;
    c.cmd    = CMD_WRITE;
    c.slot   = SLOT_W'(s);
    c.st     = st;
    c.prio   = PRIO_W'(p);
    c.cnt    = CNT_W'(n);
    c.in_set = in_set;
    return c;
  endfunction

  function automatic sched_cmd_t rand_task_write();
    sched_cmd_t c;
    c.cmd    = CMD_WRITE;
    c.slot   = SLOT_W'(($urandom_range(0, 99) < 80) ? $urandom_range(0, 7)
                                                    : $urandom_range(0, 63));
    c.st     = ($urandom_range(0, 99) < 75) ? ST_RUNNING : STATE_W'($urandom_range(1, 7));
    c.prio   = PRIO_W'(($urandom_range(0, 99) < 80) ? $urandom_range(0, 8)
                                                    : $urandom_range(0, 127));
    c.cnt    = CNT_W'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 6)
                                                   : $urandom_range(0, 255));
    c.in_set = ($urandom_range(0, 99) < 90);
    return c;
  endfunction

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (idle_on && $urandom_range(0, 99) < 25) begin
      res_if.ready <= 1'b0;
      stall_left = pick_stall() - 1;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // ---------------- checking ----------------

  task automatic check_field(input string fname, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    sched_result_t want;
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got task %0d counter %0d",
                 $time, res_if.current_task, res_if.current_counter);
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("current_task", CNT_W'(want.task_id), CNT_W'(res_if.current_task));
        check_field("switched", CNT_W'(want.switched), CNT_W'(res_if.switched));
        check_field("recomputed", CNT_W'(want.recomputed), CNT_W'(res_if.recomputed));
        check_field("none_ready", CNT_W'(want.none_ready), CNT_W'(res_if.none_ready));
        check_field("current_counter", want.counter, res_if.current_counter);
      end
    end
  end

  // ---------------- tests ----------------

  task automatic test_boot_task();
    issue(op_cmd(CMD_SCHED));
    issue(op_cmd(CMD_TICK));
  endtask

  task automatic test_slot_write();
    issue(slot_write(63, ST_RUNNING, 127, 255, 1'b1));
    issue(slot_write(1, ST_UNDEF_MAX, 0, 0, 1'b0));
    issue(slot_write(2, ST_UNDEF_MIN, 127, 200, 1'b1));
    issue(op_cmd(CMD_SCHED));
    issue(op_cmd(CMD_TICK));
  endtask

  // equal counters on slots 0, 62 and 63: lowest slot wins
  task automatic test_tie_break();
    issue(slot_write(63, ST_RUNNING, 127, 14, 1'b1));
    issue(slot_write(62, ST_RUNNING, 1, 14, 1'b1));
    issue(op_cmd(CMD_SCHED));
  endtask

  task automatic test_exit();
    issue(op_cmd(CMD_EXIT));
    issue(op_cmd(CMD_EXIT));
  endtask

  task automatic test_tick_expiry();
    issue(slot_write(63, ST_RUNNING, 127, 1, 1'b1));
    issue(op_cmd(CMD_TICK));
    issue(slot_write(63, ST_RUNNING, 2, 0, 1'b1));
    issue(op_cmd(CMD_TICK));
  endtask

  task automatic test_blocked_states();
    issue(slot_write(3, ST_INTR, 9, 250, 1'b1));
    issue(slot_write(4, ST_UNINTR, 9, 251, 1'b1));
    issue(slot_write(5, ST_STOPPED, 9, 252, 1'b1));
    issue(op_cmd(CMD_SCHED));
  endtask

  task automatic test_none_ready();
    issue(slot_write(63, ST_RUNNING, 9, 9, 1'b0));
    issue(op_cmd(CMD_TICK));
    issue(op_cmd(CMD_EXIT));
    issue(slot_write(6, ST_RUNNING, 0, 0, 1'b1));
    issue(op_cmd(CMD_SCHED));
  endtask

  // bursts: build a task set, then run ticks, requests and exits on it; some bursts send random noise commands
  task automatic test_random_traffic();
    int sent;
    int r;
    int k;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 8) begin
        k = $urandom_range(1, 5);
        repeat (k) issue(rand_task_write());
        sent += k;
        k = $urandom_range(4, 30);
        repeat (k) begin
          r = $urandom_range(0, 99);
          if (r < 60) issue(op_cmd(CMD_TICK));
          else if (r < 80) issue(op_cmd(CMD_SCHED));
          else issue(op_cmd(CMD_EXIT));
        end
        sent += k;
      end else begin
        k = $urandom_range(1, 10);
        repeat (k) issue(noise_cmd());
        sent += k;
      end
    end
  endtask

  initial begin
    rst_ni               = 1'b0;
    idle_on              = 1'b0;
    errors               = 0;
    stall_left           = 0;
    cycle_cnt            = 0;
    cmd_if.valid         = 1'b0;
    cmd_if.cmd           = CMD_TICK;
    cmd_if.slot          = '0;
    cmd_if.run_state     = ST_RUNNING;
    cmd_if.priority_req  = '0;
    cmd_if.start_counter = '0;
    cmd_if.slot_valid    = 1'b0;
    res_if.ready         = 1'b0;
    reset_tasks();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    idle_on = 1'b1;
    test_boot_task();
    test_slot_write();
    test_tie_break();
    test_exit();
    test_tick_expiry();
    test_blocked_states();
    test_none_ready();
    test_random_traffic();

    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
